/* hw/rtl/satq_pkg.sv */
// shared types, constants and helpers for the sorted alarm timer queue
`timescale 1ns / 1ps

package satq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned MaxFire           = 16;
  localparam int unsigned FireCntW          = $clog2(MaxFire + 1);

  localparam int unsigned DelayW  = 16;
  localparam int unsigned TagW    = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 24;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_FIRED    = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2
  } kind_e;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch the incoming transaction
    logic tick;    // loaded transaction is a tick
    logic insert;  // place the alarm (or reject) and emit its result
    logic fire;    // pop the head and emit it
    logic last;    // marks the emitted fire result as final
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head_due;
    logic next_due;
    logic out_free;
  } status_t;

  // a is not earlier than b, wrap safe
  function automatic logic not_earlier(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW-1:0] diff;
    diff = a - b;
    return ~diff[TimeW-1];
  endfunction

endpackage

/* hw/rtl/satq_ctrl.sv */
// controller state machine for the sorted alarm timer queue
`timescale 1ns / 1ps

module satq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  output logic            in_ready_o,
  input  satq_pkg::status_t status_i,
  output satq_pkg::cmd_t  cmd_o
);
  import satq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_FIRE = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [FireCntW-1:0] fire_cnt_q, fire_cnt_d;
  logic                fire_last;

  assign in_ready_o = (state_q == S_IDLE);

  // final fire of this tick when the next head is not due or the per-tick cap is hit
  assign fire_last = ~status_i.next_due || (fire_cnt_q == FireCntW'(MaxFire - 1));

  always_comb begin
    state_d    = state_q;
    fire_cnt_d = fire_cnt_q;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.tick = (in_op_i == OP_TICK);
          fire_cnt_d = '0;
          state_d    = (in_op_i == OP_TICK) ? S_FIRE : S_INS;
        end
      end
      S_INS: begin
        if (status_i.out_free) begin
          cmd_o.insert = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FIRE: begin
        if (!status_i.head_due) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.fire = 1'b1;
          cmd_o.last = fire_last;
          fire_cnt_d = fire_cnt_q + 1'b1;
          if (fire_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fire_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      fire_cnt_q <= fire_cnt_d;
    end
  end

endmodule

/* hw/rtl/satq_dp.sv */
// datapath: tick counter, sorted row of alarm cells and result register
`timescale 1ns / 1ps

module satq_dp #(
  parameter int unsigned QUEUE_DEPTH = satq_pkg::QueueDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [satq_pkg::DelayW-1:0]  in_delay_i,
  input  logic [satq_pkg::TagW-1:0]    in_tag_i,
  input  satq_pkg::cmd_t               cmd_i,
  output satq_pkg::status_t            status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   out_kind_o,
  output logic [satq_pkg::DelayW-1:0]  out_delay_o,
  output logic [satq_pkg::TagW-1:0]    out_tag_o,
  output logic                         out_last_o
);
  import satq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [TimeW-1:0]  now_q;
  logic [CntW-1:0]   cnt_q;
  logic [TimeW-1:0]  new_exp_q;
  logic [DelayW-1:0] new_dly_q;
  logic [TagW-1:0]   new_tag_q;

  logic [TimeW-1:0]  exp_q [QUEUE_DEPTH];
  logic [DelayW-1:0] dly_q [QUEUE_DEPTH];
  logic [TagW-1:0]   tag_q [QUEUE_DEPTH];

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [DelayW-1:0] out_dly_q;
  logic [TagW-1:0]   out_tag_q;
  logic              out_last_q;

  logic [QUEUE_DEPTH-1:0] ge;
  logic [QUEUE_DEPTH-1:0] shift_up;
  logic                   full;

  assign full = (cnt_q == CntW'(QUEUE_DEPTH));

  // each cell compares its own expiry against the new one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CntW'(i) < cnt_q) && not_earlier(exp_q[i], new_exp_q);
    end
    shift_up[0] = 1'b0;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      shift_up[i] = shift_up[i-1] | ge[i-1];
    end
  end

  assign status_o.head_due = (cnt_q != '0) && not_earlier(now_q, exp_q[0]);
  assign status_o.next_due = (cnt_q > CntW'(1)) && not_earlier(now_q, exp_q[1]);
  assign status_o.out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.load && cmd_i.tick) begin
        now_q <= now_q + 1'b1;
      end
      if (cmd_i.insert && !full) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.fire) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_dly_q <= in_delay_i;
      new_tag_q <= in_tag_i;
      new_exp_q <= now_q + {{(TimeW-DelayW){1'b0}}, in_delay_i};
    end
  end

  // sorted cells: shift up on insert past the slot, shift down on fire
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert && !full) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (shift_up[i]) begin
          exp_q[i] <= exp_q[(i > 0) ? i - 1 : 0];
          dly_q[i] <= dly_q[(i > 0) ? i - 1 : 0];
          tag_q[i] <= tag_q[(i > 0) ? i - 1 : 0];
        end else if (ge[i] || (CntW'(i) == cnt_q)) begin
          exp_q[i] <= new_exp_q;
          dly_q[i] <= new_dly_q;
          tag_q[i] <= new_tag_q;
        end
      end
    end else if (cmd_i.fire) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        exp_q[i] <= exp_q[i+1];
        dly_q[i] <= dly_q[i+1];
        tag_q[i] <= tag_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.insert || cmd_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      out_kind_q <= full ? KIND_REJECTED : KIND_ACCEPTED;
      out_dly_q  <= new_dly_q;
      out_tag_q  <= new_tag_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.fire) begin
      out_kind_q <= KIND_FIRED;
      out_dly_q  <= dly_q[0];
      out_tag_q  <= tag_q[0];
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_delay_o = out_dly_q;
  assign out_tag_o   = out_tag_q;
  assign out_last_o  = out_last_q;

endmodule

/* hw/rtl/sorted_alarm_timer_queue_core.sv */
// sorted alarm timer queue: an insert is accepted, then placed, and gives one result
// a tick is accepted, then pops each due alarm from the head with one result each (up to 16)
// the sorted insert is done by compares in every queue cell in parallel
// a new transaction is taken once the previous one has loaded its last result or found none due
// the result register lets it in while a result waits; a held result stalls place and fire
// reset clears the tick counter, the entry count and the result valid, queue empty
`timescale 1ns / 1ps

module sorted_alarm_timer_queue_core #(
  parameter int unsigned QUEUE_DEPTH = satq_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [satq_pkg::InDataW-1:0]  s_axis_tdata,   // delay_seconds[15:0], alarm_tag[23:16]
  input  logic                          s_axis_tuser,   // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [satq_pkg::OutDataW-1:0] m_axis_tdata,   // fired_delay[15:0], fired_tag[23:16]
  output logic [1:0]                    m_axis_tuser,   // kind
  output logic                          m_axis_tlast
);
  import satq_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [DelayW-1:0] out_dly;
  logic [TagW-1:0]   out_tag;

  satq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  satq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_delay_i  (s_axis_tdata[DelayW-1:0]),
    .in_tag_i    (s_axis_tdata[DelayW+TagW-1:DelayW]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_delay_o (out_dly),
    .out_tag_o   (out_tag),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_tag, out_dly};

`ifndef NO_ASSERTIONS
  // one transaction at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous transaction still in flight");

  // insert answers are always the only result of their transaction
  a_insert_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_FIRED) |-> m_axis_tlast)
    else $error("insert result without last");

  // datapath is never told to pop and insert together, nor to load alongside either
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.fire && cmd.insert) && !(cmd.load && (cmd.fire || cmd.insert)))
    else $error("conflicting datapath commands");
`endif

endmodule
